// ===== rtl/core/mtfrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mtfrc_pkg
// shared types and codes for the move-to-front region cache
// ----------------------------------------------------------------------------
package mtfrc_pkg;

  localparam int ADDR_W = 32;
  localparam int END_W  = 33;
  localparam int SIZE_W = 17;

  // operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_FILL   = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  localparam logic [SIZE_W-1:0] SPAN_CAP_RESET = SIZE_W'(4096);

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] access_bytes;
    logic              want_write;
    logic [ADDR_W-1:0] fill_start;
    logic [END_W-1:0]  fill_end;
    logic              fill_committed;
    logic              fill_readable;
    logic              fill_writable;
  } mtfrc_in_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] region_start;
    logic [END_W-1:0]  region_end;
    logic              region_readable;
    logic              region_writable;
    logic              access_ok;
    logic [SIZE_W-1:0] span_bytes;
  } mtfrc_out_t;

  // one cached region
  typedef struct packed {
    logic [ADDR_W-1:0] start_addr;
    logic [END_W-1:0]  end_addr;
    logic              readable;
    logic              writable;
  } mtfrc_entry_t;

  // result of the first-match search
  typedef struct packed {
    logic         hit;
    mtfrc_entry_t entry;
  } mtfrc_hit_t;

endpackage

// ===== rtl/core/move_to_front_region_cache_core.sv =====
// ----------------------------------------------------------------------------
// move_to_front_region_cache_core
// fully associative region cache kept in most-recently-used order as a row
// of shifting cells, with access check and readable span per beat
// ----------------------------------------------------------------------------
// the cells compare in the accept cycle; the beat and its match vector are
//   registered as the block enters ST_EXEC, where the pick, the row shift
//   and the access check run and the result is registered; no new beat is
//   taken in ST_EXEC, and a stalled output holds the block there until taken
// reset: synchronous, clears the fill count (cache empty), handshake state
//   and sets span_cap to 4096; cell contents are left as they are
module move_to_front_region_cache_core #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mtfrc_pkg::mtfrc_in_t          in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output mtfrc_pkg::mtfrc_out_t         out_data,
  // span_cap register
  input  logic                          cfg_wr_en,
  input  logic [mtfrc_pkg::SIZE_W-1:0]  cfg_wr_data
);
  import mtfrc_pkg::*;

  localparam int                 CNT_W   = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0]   CNT_MAX = CNT_W'(ENTRIES);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  // control and held beat
  state_t             state_r, state_nxt;
  mtfrc_in_t          item_r, item_nxt;
  logic [ENTRIES-1:0] match_r, match_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  mtfrc_out_t         out_data_r, out_data_nxt;
  logic [SIZE_W-1:0]  span_cap_r, span_cap_nxt;

  // cell row
  mtfrc_entry_t [ENTRIES-1:0] cell_entry;
  logic [ENTRIES-1:0]         cell_match;
  logic [ENTRIES-1:0]         cell_shift;
  mtfrc_entry_t               front_entry;

  mtfrc_hit_t         found;
  logic [ENTRIES-1:0] front_mask;

  logic accept;
  logic produce;
  logic is_lookup, is_fill, is_flush;
  logic fill_insert;
  logic lookup_gate;

  // region under report
  mtfrc_entry_t      fill_entry;
  mtfrc_entry_t      rep;
  logic              report_on;
  logic [END_W-1:0]  addr_ext;
  logic [END_W-1:0]  avail;
  logic [END_W-1:0]  bytes_ext;
  logic [END_W-1:0]  cap_ext;
  logic              in_region;
  logic              mark;
  mtfrc_out_t        result;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign produce  = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  assign is_lookup   = (item_r.operation == OP_LOOKUP);
  assign is_fill     = (item_r.operation == OP_FILL);
  assign is_flush    = (item_r.operation == OP_FLUSH);
  assign fill_insert = is_fill && item_r.fill_committed;

  // null address on lookup skips the search, so no reorder either
  assign lookup_gate = (in_data.operation == OP_LOOKUP) && (in_data.address != '0);

  // region marks as stored: writable only if readable, both need commit
  assign fill_entry.start_addr = item_r.fill_start;
  assign fill_entry.end_addr   = item_r.fill_end;
  assign fill_entry.readable   = item_r.fill_committed && item_r.fill_readable;
  assign fill_entry.writable   = fill_entry.readable && item_r.fill_writable;

  // slot 0 takes either the new region or the entry that was hit
  assign front_entry = is_fill ? fill_entry : found.entry;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      mtfrc_entry_t prev_entry;
      logic         slot_valid;

      if (g == 0) begin : g_head
        assign prev_entry = front_entry;
      end else begin : g_body
        assign prev_entry = cell_entry[g-1];
      end

      assign slot_valid    = (CNT_W'(g) < count_r);
      // a hit shifts the slots up to and including the hit one
      assign cell_shift[g] = produce &&
                             (fill_insert || (is_lookup && found.hit && front_mask[g]));

      mtfrc_cell u_cell (
        .clk         (clk),
        .shift_en    (cell_shift[g]),
        .valid       (slot_valid),
        .prev_entry  (prev_entry),
        .lookup_addr (in_data.address),
        .entry       (cell_entry[g]),
        .match       (cell_match[g])
      );
    end
  endgenerate

  mtfrc_select #(
    .ENTRIES (ENTRIES)
  ) u_select (
    .match      (match_r),
    .entries    (cell_entry),
    .found      (found),
    .front_mask (front_mask)
  );

  // access check and span against the reported region
  assign rep       = is_fill ? fill_entry : found.entry;
  assign report_on = is_fill || (is_lookup && found.hit);
  assign addr_ext  = {1'b0, item_r.address};
  assign bytes_ext = END_W'(item_r.access_bytes);
  assign cap_ext   = END_W'(span_cap_r);
  assign in_region = (item_r.address >= rep.start_addr) && (addr_ext < rep.end_addr);
  assign avail     = rep.end_addr - addr_ext;
  assign mark      = item_r.want_write ? rep.writable : rep.readable;

  always_comb begin
    result = '0;
    if (report_on) begin
      result.hit             = is_lookup;
      result.region_start    = rep.start_addr;
      result.region_end      = rep.end_addr;
      result.region_readable = rep.readable;
      result.region_writable = rep.writable;
      result.access_ok       = (item_r.address != '0) && (item_r.access_bytes != '0) &&
                               mark && in_region && (bytes_ext <= avail);
      if (rep.readable && in_region) begin
        result.span_bytes = (avail < cap_ext) ? avail[SIZE_W-1:0] : span_cap_r;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    match_nxt     = match_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    span_cap_nxt  = span_cap_r;

    if (cfg_wr_en) begin
      span_cap_nxt = cfg_wr_data;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_nxt  = in_data;
          match_nxt = cell_match & {ENTRIES{lookup_gate}};
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (produce) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result;
          state_nxt     = ST_IDLE;
          if (is_flush) begin
            count_nxt = '0;
          end else if (fill_insert && (count_r < CNT_MAX)) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      span_cap_r  <= SPAN_CAP_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      span_cap_r  <= span_cap_nxt;
    end
    item_r     <= item_nxt;
    match_r    <= match_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // fill count stays within the row
  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("fill count beyond row length");

  // one beat at a time: an accept closes the input for the next cycle
  a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input accepted while a beat is in work");

  // shifting slots always form a run from slot 0
  a_front_run : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> ((cell_shift & (cell_shift + ENTRIES'(1))) == '0))
    else $error("row shift mask not contiguous from the front");

  // a flush leaves the cache empty
  a_flush_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (produce && is_flush) |=> (count_r == '0))
    else $error("flush did not empty the cache");

endmodule

// ===== rtl/core/mtfrc_cell.sv =====
// ----------------------------------------------------------------------------
// mtfrc_cell
// one cache slot: holds a region, compares it with the lookup address and
// takes its neighbor's region when the row shifts
// ----------------------------------------------------------------------------
module mtfrc_cell (
  input  logic                            clk,
  input  logic                            shift_en,
  input  logic                            valid,
  input  mtfrc_pkg::mtfrc_entry_t         prev_entry,
  input  logic [mtfrc_pkg::ADDR_W-1:0]    lookup_addr,
  output mtfrc_pkg::mtfrc_entry_t         entry,
  output logic                            match
);
  import mtfrc_pkg::*;

  mtfrc_entry_t entry_r;
  mtfrc_entry_t entry_nxt;
  logic [END_W-1:0] addr_ext;

  assign entry_nxt = shift_en ? prev_entry : entry_r;

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign addr_ext = {1'b0, lookup_addr};
  assign entry    = entry_r;
  assign match    = valid && (lookup_addr >= entry_r.start_addr) &&
                    (addr_ext < entry_r.end_addr);

endmodule

// ===== rtl/core/mtfrc_select.sv =====
// ----------------------------------------------------------------------------
// mtfrc_select
// first-match pick over the cell row and the mask of cells that shift
// ----------------------------------------------------------------------------
module mtfrc_select #(
  parameter int ENTRIES = 16
) (
  input  logic [ENTRIES-1:0]                    match,
  input  mtfrc_pkg::mtfrc_entry_t [ENTRIES-1:0] entries,
  output mtfrc_pkg::mtfrc_hit_t                 found,
  output logic [ENTRIES-1:0]                    front_mask
);
  import mtfrc_pkg::*;

  localparam logic [ENTRIES-1:0] ONES = '1;

  logic [ENTRIES-1:0] prior_hit;
  logic [ENTRIES-1:0] first;
  mtfrc_entry_t       picked;

  // a match in some lower slot masks every slot above it
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      prior_hit[i] = |(match & (ONES >> (ENTRIES - i)));
    end
  end

  assign first      = match & ~prior_hit;
  assign front_mask = ~prior_hit;

  always_comb begin
    picked = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      picked = picked | (entries[i] & {$bits(mtfrc_entry_t){first[i]}});
    end
  end

  assign found.hit   = |match;
  assign found.entry = picked;

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the move-to-front region cache core: lookups,
// fills and flushes go in over the input channel while an in-bench copy of
// the cache predicts every result beat, and each result is compared field
// by field in arrival order, under several span_cap settings
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mtfrc_pkg::*;

  localparam int REGION_SLOTS = 16;
  localparam int POOL_SIZE    = 32;
  // code the block never defines, must answer all zeros
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  mtfrc_in_t         in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  mtfrc_out_t        out_data;
  logic              cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0] cfg_wr_data = '0;

  // mirror of the cache: regions in most-recently-used order, slot 0 newest
  mtfrc_entry_t      cached_regions [REGION_SLOTS];
  int                cached_count;
  logic [SIZE_W-1:0] model_span_cap;

  // results still owed by the block, oldest first
  mtfrc_out_t        pending_results [$];

  // address regions the traffic draws from, more than the cache holds
  logic [ADDR_W-1:0] pool_start [POOL_SIZE];
  logic [END_W-1:0]  pool_end   [POOL_SIZE];

  int                mismatches = 0;
  int                beats_sent = 0;
  // when set neither side idles
  logic              steady = 1'b0;

  always #5 clk = ~clk;

  move_to_front_region_cache_core #(
    .ENTRIES (REGION_SLOTS)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // first cached region that holds the address, -1 on a miss
  function automatic int region_slot(input logic [ADDR_W-1:0] addr);
    for (int i = 0; i < cached_count; i++) begin
      if (addr >= cached_regions[i].start_addr && addr < cached_regions[i].end_addr) begin
        return i;
      end
    end
    return -1;
  endfunction

  // access check and readable span of one beat against one region
  function automatic mtfrc_out_t grade_access(input mtfrc_in_t beat,
                                              input mtfrc_entry_t rgn,
                                              input logic found);
    mtfrc_out_t  res;
    logic        holds;
    logic        mark;
    logic [33:0] room;
    holds = (beat.address >= rgn.start_addr) && (beat.address < rgn.end_addr);
    room  = holds ? (34'(rgn.end_addr) - 34'(beat.address)) : '0;
    mark  = beat.want_write ? rgn.writable : rgn.readable;
    res.hit             = found;
    res.region_start    = rgn.start_addr;
    res.region_end      = rgn.end_addr;
    res.region_readable = rgn.readable;
    res.region_writable = rgn.writable;
    res.access_ok       = (beat.address != '0) && (beat.access_bytes != '0) && mark && holds
                          && (34'(beat.access_bytes) <= room);
    if (rgn.readable && holds) begin
      res.span_bytes = SIZE_W'((room < 34'(model_span_cap)) ? room : 34'(model_span_cap));
    end else begin
      res.span_bytes = '0;
    end
    return res;
  endfunction

  // advance the mirror by one accepted beat and give the result it owes
  function automatic mtfrc_out_t apply_beat(input mtfrc_in_t beat);
    mtfrc_out_t   res;
    mtfrc_entry_t fresh;
    int           slot;
    res = '0;
    case (beat.operation)
      OP_LOOKUP: begin
        // null address: no search, no reordering
        if (beat.address != '0) begin
          slot = region_slot(beat.address);
          if (slot >= 0) begin
            fresh = cached_regions[slot];
            for (int j = slot; j > 0; j--) cached_regions[j] = cached_regions[j-1];
            cached_regions[0] = fresh;
            res = grade_access(beat, fresh, 1'b1);
          end
        end
      end
      OP_FILL: begin
        fresh.start_addr = beat.fill_start;
        fresh.end_addr   = beat.fill_end;
        fresh.readable   = beat.fill_committed & beat.fill_readable;
        fresh.writable   = fresh.readable & beat.fill_writable;
        // only committed regions are cached, oldest drops when full
        if (beat.fill_committed) begin
          if (cached_count < REGION_SLOTS) cached_count++;
          for (int j = cached_count - 1; j > 0; j--) cached_regions[j] = cached_regions[j-1];
          cached_regions[0] = fresh;
        end
        res = grade_access(beat, fresh, 1'b0);
      end
      OP_FLUSH: cached_count = 0;
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // output side stalls at random unless in a steady stretch
  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 14);
  end

  // one beat into the block, predicted at the edge it is taken
  task automatic send_beat(input mtfrc_in_t beat);
    int gap;
    if (!steady && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_beat(beat));
    beats_sent++;
  endtask

  // sender holds off until every owed result is in, then lets the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_span_cap(input logic [SIZE_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    model_span_cap  = value;
  endtask

  function automatic mtfrc_in_t mk_beat(input logic [1:0] op,
                                        input logic [ADDR_W-1:0] addr,
                                        input logic [SIZE_W-1:0] bytes,
                                        input logic ww,
                                        input logic [ADDR_W-1:0] fs,
                                        input logic [END_W-1:0] fe,
                                        input logic c, input logic r, input logic w);
    mtfrc_in_t beat;
    beat.operation      = op;
    beat.address        = addr;
    beat.access_bytes   = bytes;
    beat.want_write     = ww;
    beat.fill_start     = fs;
    beat.fill_end       = fe;
    beat.fill_committed = c;
    beat.fill_readable  = r;
    beat.fill_writable  = w;
    return beat;
  endfunction

  // access size around the room left in the region, plus the extremes
  function automatic logic [SIZE_W-1:0] pick_bytes(input logic [33:0] room);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SIZE_W'(1);
      2: return (room == 0) ? SIZE_W'(1) : ((room > 34'h1FFFF) ? SIZE_W'(65536)
                                                                : SIZE_W'(room));
      3: return (room < 34'h1FFFF) ? SIZE_W'(room + 1) : SIZE_W'(17'h1FFFF);
      4: return SIZE_W'(65536);
      5: return SIZE_W'(17'h1FFFF);
      6, 7: return SIZE_W'($urandom_range(1, 64));
      default: return SIZE_W'($urandom);
    endcase
  endfunction

  // disjoint regions, one per 128 MiB window, the last one at the top of memory
  task automatic build_pool();
    logic [ADDR_W-1:0] s;
    int                size;
    for (int k = 0; k < POOL_SIZE - 1; k++) begin
      s = {5'(k), 1'b0, 26'($urandom)};
      case ($urandom_range(0, 2))
        0: size = $urandom_range(1, 64);
        1: size = $urandom_range(65, 4096);
        default: size = $urandom_range(4097, 32'h60000);
      endcase
      pool_start[k] = s;
      pool_end[k]   = END_W'(s) + END_W'(size);
    end
    pool_start[POOL_SIZE-1] = 32'hFFFF_0000 + $urandom_range(0, 32'hFF00);
    pool_end[POOL_SIZE-1]   = 33'h1_0000_0000;
  endtask

  // any field at random, unused operation code and inverted fills included
  function automatic mtfrc_in_t mk_noise();
    mtfrc_in_t beat;
    beat.operation = 2'($urandom_range(0, 3));
    if (beat.operation == OP_FLUSH) beat.operation = OP_UNUSED;
    beat.address        = ($urandom_range(0, 9) == 0) ? '0 : ADDR_W'($urandom);
    beat.access_bytes   = SIZE_W'($urandom);
    beat.want_write     = 1'($urandom);
    beat.fill_start     = ADDR_W'($urandom);
    case ($urandom_range(0, 4))
      0, 1: beat.fill_end = END_W'($urandom);
      2, 3: beat.fill_end = END_W'(beat.fill_start) + END_W'($urandom_range(0, 4096));
      default: beat.fill_end = 33'h1_0000_0000;
    endcase
    beat.fill_committed = 1'($urandom);
    beat.fill_readable  = 1'($urandom);
    beat.fill_writable  = 1'($urandom);
    return beat;
  endfunction

  // lookup into a pool region, the fill a miss calls for, maybe a second lookup
  task automatic run_episode();
    int                idx;
    int                sel;
    logic [ADDR_W-1:0] s;
    logic [END_W-1:0]  e;
    logic [ADDR_W-1:0] addr;
    logic [33:0]       room;
    logic [SIZE_W-1:0] bytes;
    logic              ww;
    // bias toward a working set that fits, so hits are common
    idx = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 11) : $urandom_range(0, POOL_SIZE - 1);
    s   = pool_start[idx];
    e   = pool_end[idx];
    sel = $urandom_range(0, 99);
    if (sel < 75) addr = s + $urandom_range(0, 32'(e - END_W'(s) - 1));
    else if (sel < 85) addr = ADDR_W'(e - 1);
    else if (sel < 93) addr = ADDR_W'(e);
    else addr = s - 1;
    room  = (addr >= s && addr < e) ? (34'(e) - 34'(addr)) : '0;
    bytes = pick_bytes(room);
    ww    = 1'($urandom);
    send_beat(mk_beat(OP_LOOKUP, addr, bytes, ww, ADDR_W'($urandom), END_W'($urandom),
                      1'($urandom), 1'($urandom), 1'($urandom)));
    if (room != 0 && region_slot(addr) < 0) begin
      send_beat(mk_beat(OP_FILL, addr, bytes, ww, s, e, $urandom_range(0, 99) < 90,
                        $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 60));
    end
    if ($urandom_range(0, 1) == 1) begin
      addr  = s + $urandom_range(0, 32'(e - END_W'(s) - 1));
      bytes = pick_bytes(34'(e) - 34'(addr));
      send_beat(mk_beat(OP_LOOKUP, addr, bytes, 1'($urandom), ADDR_W'($urandom),
                        END_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)));
    end
  endtask

  task automatic random_traffic(input int count);
    int target;
    int pick;
    target = beats_sent + count;
    while (beats_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_beat(mk_beat(OP_FLUSH, ADDR_W'($urandom), SIZE_W'($urandom), 1'($urandom),
                          ADDR_W'($urandom), END_W'($urandom), 1'($urandom),
                          1'($urandom), 1'($urandom)));
      end else if (pick < 15) begin
        send_beat(mk_noise());
      end else begin
        run_episode();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked beats for the edges of every field and operation
  task automatic test_directed();
    // empty cache, then null address
    send_beat(mk_beat(OP_LOOKUP, 32'h1000, 17'd4, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0));
    send_beat(mk_beat(OP_LOOKUP, '0, 17'd4, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0));
    // committed read-write region, write that exactly fits
    send_beat(mk_beat(OP_FILL, 32'h1800, 17'h800, 1'b1, 32'h1000, 33'h2000, 1'b1, 1'b1, 1'b1));
    send_beat(mk_beat(OP_LOOKUP, 32'h1FFF, 17'd1, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0));
    // one byte too many
    send_beat(mk_beat(OP_LOOKUP, 32'h1800, 17'h801, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0));
    // zero size still reorders and gives the span
    send_beat(mk_beat(OP_LOOKUP, 32'h1800, 17'd0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0));
    // null address with a cached region around
    send_beat(mk_beat(OP_LOOKUP, '0, 17'd1, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0));
    // uncommitted region is reported but not cached
    send_beat(mk_beat(OP_FILL, 32'h3000, 17'd16, 1'b0, 32'h3000, 33'h4000, 1'b0, 1'b1, 1'b1));
    send_beat(mk_beat(OP_LOOKUP, 32'h3000, 17'd16, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0));
    // writable without readable is forced off
    send_beat(mk_beat(OP_FILL, 32'h5000, 17'd8, 1'b1, 32'h5000, 33'h6000, 1'b1, 1'b0, 1'b1));
    send_beat(mk_beat(OP_LOOKUP, 32'h5000, 17'd8, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0));
    // inverted and empty regions are cached but never match
    send_beat(mk_beat(OP_FILL, 32'h7800, 17'd1, 1'b0, 32'h8000, 33'h7000, 1'b1, 1'b1, 1'b0));
    send_beat(mk_beat(OP_FILL, 32'h9000, 17'd1, 1'b0, 32'h9000, 33'h9000, 1'b1, 1'b1, 1'b1));
    send_beat(mk_beat(OP_LOOKUP, 32'h7800, 17'd1, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0));
    send_beat(mk_beat(OP_LOOKUP, 32'h9000, 17'd1, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0));
    // region up to the very top of memory
    send_beat(mk_beat(OP_FILL, 32'hFFFF_FFFF, 17'd1, 1'b1, 32'hFFFF_0000, 33'h1_0000_0000,
                      1'b1, 1'b1, 1'b1));
    send_beat(mk_beat(OP_LOOKUP, 32'hFFFF_FFFF, 17'd1, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0));
    send_beat(mk_beat(OP_LOOKUP, 32'hFFFF_0000, 17'd65536, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0));
    send_beat(mk_beat(OP_LOOKUP, 32'hFFFF_0000, 17'h1FFFF, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0));
    // unused code with every field set
    send_beat(mk_beat(OP_UNUSED, 32'hFFFF_FFFF, 17'h1FFFF, 1'b1, 32'hFFFF_FFFF,
                      33'h1_FFFF_FFFF, 1'b1, 1'b1, 1'b1));
    // oldest region back to the front
    send_beat(mk_beat(OP_LOOKUP, 32'h1000, 17'd2, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0));
    // flush, then everything misses
    send_beat(mk_beat(OP_FLUSH, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0));
    send_beat(mk_beat(OP_LOOKUP, 32'h1000, 17'd2, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0));
  endtask

  // random traffic under a range of span caps, extremes and zero included
  task automatic test_span_caps();
    logic [SIZE_W-1:0] caps [6];
    caps = '{SIZE_W'(1), SIZE_W'(65536), SIZE_W'(0), SIZE_W'(65535),
             SIZE_W'($urandom_range(2, 65535)), SPAN_CAP_RESET};
    foreach (caps[i]) begin
      set_span_cap(caps[i]);
      build_pool();
      random_traffic(110);
    end
  endtask

  // sender stops mid-stream until every owed result has come back
  task automatic test_pause();
    random_traffic(30);
    drain_results();
    random_traffic(30);
  endtask

  // a long stretch with neither side idling
  task automatic test_steady();
    steady = 1'b1;
    random_traffic(100);
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string name, input logic [END_W-1:0] want_v,
                               input logic [END_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // each result beat against the oldest owed result
  always @(posedge clk) begin : check_results
    mtfrc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction waiting");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("hit", END_W'(want.hit), END_W'(out_data.hit));
        compare_field("region_start", END_W'(want.region_start), END_W'(out_data.region_start));
        compare_field("region_end", want.region_end, out_data.region_end);
        compare_field("region_readable", END_W'(want.region_readable),
                      END_W'(out_data.region_readable));
        compare_field("region_writable", END_W'(want.region_writable),
                      END_W'(out_data.region_writable));
        compare_field("access_ok", END_W'(want.access_ok), END_W'(out_data.access_ok));
        compare_field("span_bytes", END_W'(want.span_bytes), END_W'(out_data.span_bytes));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------

  initial begin
    cached_count   = 0;
    model_span_cap = SPAN_CAP_RESET;
    build_pool();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_span_caps();
    test_pause();
    test_steady();

    // everything owed is in, then wait for stray beats before the verdict
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mtfrc_pkg.sv
rtl/core/mtfrc_cell.sv
rtl/core/mtfrc_select.sv
rtl/core/move_to_front_region_cache_core.sv
sim/testbench.sv
